// File: hdl/sfcb_pkg.sv
// Shared types and constants for the Shannon-Fano code builder.
package sfcb_pkg;

   localparam int CODE_BITS = 64;
   localparam int LEN_BITS  = 7;
   localparam int IDX_BITS  = 6;
   localparam int REQ_BITS  = 32;
   localparam int RSP_BITS  = 80;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_ALIGN,
      ST_START,
      ST_POP,
      ST_WAIT,
      ST_DECIDE,
      ST_SUM,
      ST_MARK,
      ST_PUSH_R,
      ST_PUSH_L,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic shift;
      logic append;
      logic bit_val;
   } cell_ctl_type;

endpackage

// File: hdl/sfcb_cell.sv
// One ring cell: holds a symbol's count, code and length, takes its neighbor's record.
module sfcb_cell #(
   parameter int COUNT_BITS = 32
) (
   input  logic                          clock,
   input  sfcb_pkg::cell_ctl_type        ctl,
   input  logic [COUNT_BITS-1:0]         cnt_in,
   input  logic [sfcb_pkg::CODE_BITS-1:0] code_in,
   input  logic [sfcb_pkg::LEN_BITS-1:0] len_in,
   output logic [COUNT_BITS-1:0]         cnt_q,
   output logic [sfcb_pkg::CODE_BITS-1:0] code_q,
   output logic [sfcb_pkg::LEN_BITS-1:0] len_q
);
   import sfcb_pkg::*;

   logic [COUNT_BITS-1:0] cnt_ff;
   logic [CODE_BITS-1:0]  code_ff, code_in_w;
   logic [LEN_BITS-1:0]   len_ff, len_in_w;

   // append one code bit while the record passes through
   always_comb begin
      if (ctl.append) begin
         code_in_w = {code_in[CODE_BITS-2:0], ctl.bit_val};
         len_in_w  = len_in + LEN_BITS'(1);
      end else begin
         code_in_w = code_in;
         len_in_w  = len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         cnt_ff  <= cnt_in;
         code_ff <= code_in_w;
         len_ff  <= len_in_w;
      end
   end

   assign cnt_q  = cnt_ff;
   assign code_q = code_ff;
   assign len_q  = len_ff;
endmodule

// File: hdl/sfcb_stack.sv
// Range stack memory: one write port, one registered read port.
module sfcb_stack #(
   parameter int AW = 6,
   parameter int DW = 12
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);
   logic [DW-1:0] mem [2**AW];
   logic [DW-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;
endmodule

// File: hdl/shannon_fano_code_builder.sv
// Top level: loads counts into a ring of cells, builds Shannon-Fano codes, emits them.
//
//  channel | direction | fields
//  req     | in        | tdata: symbol_count[31:0]; tlast: final_symbol
//  rsp     | out       | tdata: symbol_index, code_word, code_length; tlast: last_code
//
// Requests are accepted only in the load state. The build then rotates the ring of
// MAX_SYMBOLS cells: one pass sums a range of three or more symbols, one more
// pass appends its bits, with stack work between ranges; at most 2*n-1 ranges,
// fewer than n of them split, are handled per alphabet before the codes are emitted.
// Alignment follows the last load when fewer than MAX_SYMBOLS symbols were loaded.
// Reset returns to loading with an empty store. A stalled rsp holds the ring.
module shannon_fano_code_builder #(
   parameter int MAX_SYMBOLS = 64,
   parameter int COUNT_BITS  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [sfcb_pkg::REQ_BITS-1:0] req_tdata,  // symbol_count[31:0]
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // symbol_index[5:0], code_word[69:6], code_length[76:70], zero[79:77]
   output logic [sfcb_pkg::RSP_BITS-1:0] rsp_tdata,
   output logic                          rsp_tlast
);
   import sfcb_pkg::*;

   localparam int IW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
   localparam int CW = $clog2(MAX_SYMBOLS + 1);
   localparam int TW = COUNT_BITS + IW + 1;
   localparam int SW = 2 * IW;

   state_type state_ff, state_in;
   logic [CW-1:0] n_ff, n_in, cnt_ff, cnt_in, top_ff, top_in, first_ff, first_in;
   logic [CW-1:0] size_ff, size_in;
   logic [IW-1:0] start_ff, start_in;
   logic [TW-1:0] total_ff, total_in, prefix_ff, prefix_in;
   logic          going_ff, going_in;
   logic          out_valid_ff, out_valid_in;
   logic [IDX_BITS-1:0]  out_idx_ff;
   logic [CODE_BITS-1:0] out_code_ff;
   logic [LEN_BITS-1:0]  out_len_ff;
   logic          out_last_ff;

   cell_ctl_type ctl [MAX_SYMBOLS];
   logic [COUNT_BITS-1:0] c_cnt  [MAX_SYMBOLS];
   logic [CODE_BITS-1:0]  c_code [MAX_SYMBOLS];
   logic [LEN_BITS-1:0]   c_len  [MAX_SYMBOLS];
   logic [COUNT_BITS-1:0] tail_cnt;
   logic [CODE_BITS-1:0]  tail_code;
   logic [LEN_BITS-1:0]   tail_len;

   logic shift, append, bit0, in_range, is_first, is_last, fits, pass_end;
   logic accept, take, load_end;
   logic [CW-1:0] n_next;
   logic [CW:0]   end_pos;
   logic [TW:0]   dbl;
   logic          st_wr, st_rd;
   logic [IW-1:0] st_waddr, st_raddr;
   logic [SW-1:0] st_wdata, st_rdata;

   genvar g;
   generate
      for (g = 0; g < MAX_SYMBOLS; g++) begin : g_cell
         if (g == MAX_SYMBOLS - 1) begin : g_tail
            sfcb_cell #(.COUNT_BITS(COUNT_BITS)) u_cell (
               .clock(clock), .ctl(ctl[g]), .cnt_in(tail_cnt), .code_in(tail_code),
               .len_in(tail_len), .cnt_q(c_cnt[g]), .code_q(c_code[g]), .len_q(c_len[g]));
         end else begin : g_body
            sfcb_cell #(.COUNT_BITS(COUNT_BITS)) u_cell (
               .clock(clock), .ctl(ctl[g]), .cnt_in(c_cnt[g+1]), .code_in(c_code[g+1]),
               .len_in(c_len[g+1]), .cnt_q(c_cnt[g]), .code_q(c_code[g]), .len_q(c_len[g]));
         end
      end
   endgenerate

   sfcb_stack #(.AW(IW), .DW(SW)) u_stack (
      .clock(clock), .wr_en(st_wr), .wr_addr(st_waddr), .wr_data(st_wdata),
      .rd_en(st_rd), .rd_addr(st_raddr), .rd_data(st_rdata));

   assign accept   = req_tvalid && req_tready;
   assign n_next   = n_ff + CW'(1);
   assign load_end = req_tlast || (n_next == CW'(MAX_SYMBOLS));
   assign take     = (state_ff == ST_EMIT) && (cnt_ff != n_ff)
                     && (!out_valid_ff || rsp_tready);
   assign pass_end = (cnt_ff == CW'(MAX_SYMBOLS - 1));
   assign end_pos  = {1'b0, CW'(start_ff)} + {1'b0, size_ff};
   assign in_range = ({1'b0, cnt_ff} >= {1'b0, CW'(start_ff)}) && ({1'b0, cnt_ff} < end_pos);
   assign is_first = (cnt_ff == CW'(start_ff));
   assign is_last  = ({1'b0, cnt_ff} == end_pos - (CW+1)'(1));
   assign dbl      = {prefix_ff + TW'(c_cnt[0]), 1'b0};
   assign fits     = dbl <= {1'b0, total_ff};
   assign bit0     = is_first || (going_ff && fits && !is_last);

   // ring control: the tail cell takes a new request or the head record
   always_comb begin
      shift  = (accept) || (state_ff == ST_ALIGN) || (state_ff == ST_SUM)
               || (state_ff == ST_MARK) || take;
      append = (state_ff == ST_MARK) && in_range;
      if (state_ff == ST_LOAD) begin
         tail_cnt  = COUNT_BITS'(req_tdata);
         tail_code = '0;
         tail_len  = '0;
      end else begin
         tail_cnt  = c_cnt[0];
         tail_code = c_code[0];
         tail_len  = c_len[0];
      end
      for (int k = 0; k < MAX_SYMBOLS; k++) begin
         ctl[k].shift   = shift;
         ctl[k].append  = (k == MAX_SYMBOLS - 1) && append;
         ctl[k].bit_val = !bit0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept && load_end) begin
               state_in = (n_next == CW'(MAX_SYMBOLS)) ? ST_START : ST_ALIGN;
            end
         end
         ST_ALIGN:  if (cnt_ff == CW'(1)) state_in = ST_START;
         ST_START:  state_in = ST_DECIDE;
         ST_POP:    state_in = (top_ff == '0) ? ST_EMIT : ST_WAIT;
         ST_WAIT:   state_in = ST_DECIDE;
         ST_DECIDE: state_in = (size_ff <= CW'(2)) ? ST_MARK : ST_SUM;
         ST_SUM:    if (pass_end) state_in = ST_MARK;
         ST_MARK: begin
            if (pass_end) state_in = (size_ff <= CW'(2)) ? ST_POP : ST_PUSH_R;
         end
         ST_PUSH_R: state_in = ST_PUSH_L;
         ST_PUSH_L: state_in = ST_POP;
         ST_EMIT:   if (cnt_ff == n_ff) state_in = ST_LOAD;
         default:   state_in = ST_LOAD;
      endcase
   end

   // datapath and outputs
   always_comb begin
      n_in = n_ff; cnt_in = cnt_ff; top_in = top_ff; first_in = first_ff;
      size_in = size_ff; start_in = start_ff; total_in = total_ff;
      prefix_in = prefix_ff; going_in = going_ff;
      st_wr = 1'b0; st_rd = 1'b0;
      st_waddr = top_ff[IW-1:0];
      st_raddr = IW'(top_ff - CW'(1));
      st_wdata = '0;
      req_tready = (state_ff == ST_LOAD);
      out_valid_in = out_valid_ff;
      if (take) out_valid_in = 1'b1;
      else if (rsp_tready) out_valid_in = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               n_in   = n_next;
               cnt_in = CW'(MAX_SYMBOLS) - n_next;
            end
         end
         ST_ALIGN: cnt_in = cnt_ff - CW'(1);
         ST_START: begin
            start_in = '0;
            size_in  = n_ff;
            top_in   = '0;
         end
         ST_POP: begin
            cnt_in = '0;
            if (top_ff != '0) begin
               st_rd  = 1'b1;
               top_in = top_ff - CW'(1);
            end
         end
         ST_WAIT: begin
            start_in = st_rdata[SW-1:IW];
            size_in  = CW'(st_rdata[IW-1:0]) + CW'(1);
         end
         ST_DECIDE: begin
            cnt_in = '0; total_in = '0; prefix_in = '0; going_in = 1'b1; first_in = '0;
         end
         ST_SUM: begin
            if (in_range) total_in = total_ff + TW'(c_cnt[0]);
            cnt_in = pass_end ? '0 : cnt_ff + CW'(1);
         end
         ST_MARK: begin
            if (in_range) begin
               going_in = going_ff && fits;
               if (bit0) begin
                  prefix_in = prefix_ff + TW'(c_cnt[0]);
                  first_in  = first_ff + CW'(1);
               end
            end
            cnt_in = pass_end ? '0 : cnt_ff + CW'(1);
         end
         ST_PUSH_R: begin
            st_wr    = 1'b1;
            st_wdata = {IW'(CW'(start_ff) + first_ff), IW'(size_ff - first_ff - CW'(1))};
            top_in   = top_ff + CW'(1);
         end
         ST_PUSH_L: begin
            st_wr    = 1'b1;
            st_wdata = {start_ff, IW'(first_ff - CW'(1))};
            top_in   = top_ff + CW'(1);
         end
         ST_EMIT: begin
            if (take) cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == n_ff) n_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         n_ff         <= '0;
         cnt_ff       <= '0;
         top_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         cnt_ff       <= cnt_in;
         top_ff       <= top_in;
         out_valid_ff <= out_valid_in;
      end
      first_ff  <= first_in;
      size_ff   <= size_in;
      start_ff  <= start_in;
      total_ff  <= total_in;
      prefix_ff <= prefix_in;
      going_ff  <= going_in;
      if (take) begin
         out_idx_ff  <= IDX_BITS'(cnt_ff);
         out_code_ff <= c_code[0];
         out_len_ff  <= c_len[0];
         out_last_ff <= (cnt_ff + CW'(1) == n_ff);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_len_ff, out_code_ff, out_idx_ff};
   assign rsp_tlast  = out_last_ff;

   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      top_ff <= CW'(MAX_SYMBOLS))
      else $error("range stack overflow");
   a_build_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> state_ff != ST_LOAD)
      else $error("last request did not start a build");
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> out_len_ff != '0)
      else $error("emitted code without bits");
   a_load_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |-> n_ff < CW'(MAX_SYMBOLS))
      else $error("store overfilled");
endmodule
